// File: rtl/dpb_pkg.sv
// shared widths, register codes and sideband type for the depth back-projection block
package dpb_pkg;

    localparam int PIX_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int FOCAL_W    = 24;
    localparam int CENTER_W   = 20;
    localparam int DIFF_W     = 20;
    localparam int PROD_W     = DEPTH_W + DIFF_W;
    localparam int NUM_W      = PROD_W + 8 + 1;
    localparam int QUO_W      = 32;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 2;

    // quotient bits resolved in each divider stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;
    // diff, multiply, numerator setup, divider stages, sign and clamp
    localparam int AXIS_LAT        = 3 + DIV_STAGES + 1;

    localparam int IN_W  = 2 * PIX_W + DEPTH_W + 3 * COLOR_W;
    localparam int OUT_W = 2 * COORD_W + DEPTH_W + 3 * COLOR_W;
    localparam int BUF_W = OUT_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               pv;
        logic [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } side_t;

endpackage

// File: rtl/depth_pixel_backprojection.sv
// top level: config registers, sideband line, two projection axes and the output buffer

// Back-projects one depth pixel per item through a pinhole model: x = z*(u-cx)/fx and
// y = z*(v-cy)/fy in mm with 8 fractional bits, rounded half away from zero and clamped
// to 32 bits signed; z and colour pass through, and a zero depth or an off-frame pixel
// gives an invalid point with all fields zero. One item is taken per clock while the
// skid stage is empty. From input accept an item passes 20 pipeline stages, set by the
// divider which resolves two quotient bits per stage, plus the output register. A stalled
// output is absorbed by a skid stage, so one more item is taken before the pipeline
// freezes. Configuration writes take effect at once and belong between frames.
module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // column, row, depth_mm, red_in, green_in, blue_in
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // point_x, point_y, point_z, red_out, green_out, blue_out
    output logic [OUT_W-1:0]     m_axis_tdata,
    // point_valid
    output logic                 m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FOCAL_W-1:0]   cfg_wdata
);

    logic [FOCAL_W-1:0]  focal_x_reg;
    logic [FOCAL_W-1:0]  focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [FOCAL_W-1:0]  focal_next;

    // a zero focal length behaves as the smallest nonzero one
    assign focal_next = (cfg_wdata == '0) ? FOCAL_W'(1) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_W'(256);
            focal_y_reg  <= FOCAL_W'(256);
            center_x_reg <= CENTER_W'(256);
            center_y_reg <= CENTER_W'(256);
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FOCAL_X:  focal_x_reg  <= focal_next;
                REG_FOCAL_Y:  focal_y_reg  <= focal_next;
                REG_CENTER_X: center_x_reg <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_wdata[CENTER_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [PIX_W-1:0]   column;
    logic [PIX_W-1:0]   row;
    logic [DEPTH_W-1:0] depth_mm;
    side_t              side_in;
    logic               pipe_en;

    assign column   = s_axis_tdata[PIX_W-1:0];
    assign row      = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign depth_mm = s_axis_tdata[2*PIX_W+DEPTH_W-1:2*PIX_W];

    assign side_in.pv    = (depth_mm != '0) && (32'(column) < MAX_COLUMNS)
                           && (32'(row) < MAX_ROWS);
    assign side_in.z     = depth_mm;
    assign side_in.red   = s_axis_tdata[2*PIX_W+DEPTH_W+COLOR_W-1:2*PIX_W+DEPTH_W];
    assign side_in.green = s_axis_tdata[2*PIX_W+DEPTH_W+2*COLOR_W-1:2*PIX_W+DEPTH_W+COLOR_W];
    assign side_in.blue  = s_axis_tdata[IN_W-1:2*PIX_W+DEPTH_W+2*COLOR_W];

    assign s_axis_tready = pipe_en;

    // valid bits and pass-through fields, aligned with the axis pipelines
    logic [AXIS_LAT-1:0] vld_reg;
    side_t               side_reg [AXIS_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[AXIS_LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < AXIS_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;

    dpb_axis u_axis_x (
        .clk    (clk),
        .en     (pipe_en),
        .pix    (column),
        .depth  (depth_mm),
        .center (center_x_reg),
        .focal  (focal_x_reg),
        .coord  (coord_x)
    );

    dpb_axis u_axis_y (
        .clk    (clk),
        .en     (pipe_en),
        .pix    (row),
        .depth  (depth_mm),
        .center (center_y_reg),
        .focal  (focal_y_reg),
        .coord  (coord_y)
    );

    side_t            side_last;
    logic [BUF_W-1:0] buf_in;
    logic [BUF_W-1:0] buf_out;

    assign side_last = side_reg[AXIS_LAT-1];
    // invalid points leave every field zero
    assign buf_in = side_last.pv
                    ? {1'b1, side_last.blue, side_last.green, side_last.red,
                       side_last.z, coord_y, coord_x}
                    : '0;

    dpb_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_reg[AXIS_LAT-1]),
        .in_data  (buf_in),
        .en       (pipe_en),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (buf_out)
    );

    assign m_axis_tdata = buf_out[OUT_W-1:0];
    assign m_axis_tuser = buf_out[BUF_W-1];

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid point carries nonzero fields");

    a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser)
        |-> (m_axis_tdata[2*COORD_W+DEPTH_W-1:2*COORD_W] != '0))
        else $error("valid point with zero depth");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

endmodule

// File: rtl/dpb_axis.sv
// one coordinate axis: offset, multiply, rounded restoring divide, sign and clamp
module dpb_axis
    import dpb_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [PIX_W-1:0]           pix,
    input  logic [DEPTH_W-1:0]         depth,
    input  logic [CENTER_W-1:0]        center,
    input  logic [FOCAL_W-1:0]         focal,
    output logic [COORD_W-1:0]         coord
);

    // stage 1: signed offset from the principal point, as sign and magnitude
    logic [CENTER_W-1:0] pos;
    logic                neg1_next;
    logic [DIFF_W-1:0]   diff1_next;
    logic                neg1_reg;
    logic [DIFF_W-1:0]   diff1_reg;
    logic [DEPTH_W-1:0]  z1_reg;

    assign pos        = {pix, 8'd0};
    assign neg1_next  = pos < center;
    assign diff1_next = neg1_next ? (center - pos) : (pos - center);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= neg1_next;
            diff1_reg <= diff1_next;
            z1_reg    <= depth;
        end
    end

    // stage 2: depth times offset
    logic [PROD_W-1:0] prod2_next;
    logic [PROD_W-1:0] prod2_reg;
    logic              neg2_reg;

    assign prod2_next = {{DIFF_W{1'b0}}, z1_reg} * {{DEPTH_W{1'b0}}, diff1_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod2_reg <= prod2_next;
            neg2_reg  <= neg1_reg;
        end
    end

    // stage 3: numerator with half the divisor for rounding, overflow check
    logic [NUM_W-1:0]   sum3;
    logic               ovf3;
    logic [FOCAL_W-1:0] rem_reg [DIV_STAGES+1];
    logic [QUO_W-1:0]   low_reg [DIV_STAGES+1];
    logic [QUO_W-1:0]   quo_reg [DIV_STAGES+1];
    logic               ovf_reg [DIV_STAGES+1];
    logic               neg_reg [DIV_STAGES+1];

    assign sum3 = {1'b0, prod2_reg, 8'd0} + {{(NUM_W-FOCAL_W+1){1'b0}}, focal[FOCAL_W-1:1]};
    // quotient of 2^32 or more always clamps
    assign ovf3 = {{(FOCAL_W-(NUM_W-QUO_W)){1'b0}}, sum3[NUM_W-1:QUO_W]} >= focal;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf3 ? '0
                               : {{(FOCAL_W-(NUM_W-QUO_W)){1'b0}}, sum3[NUM_W-1:QUO_W]};
            low_reg[0] <= sum3[QUO_W-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= ovf3;
            neg_reg[0] <= neg2_reg;
        end
    end

    // divider stages, two quotient bits each
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [FOCAL_W-1:0] rem_next;
        logic [QUO_W-1:0]   low_next;
        logic [QUO_W-1:0]   quo_next;

        always_comb
        begin
            logic [FOCAL_W:0] trial;
            rem_next = rem_reg[k];
            low_next = low_reg[k];
            quo_next = quo_reg[k];
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                trial    = {rem_next, low_next[QUO_W-1]};
                low_next = {low_next[QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, focal})
                begin
                    rem_next = FOCAL_W'(trial - {1'b0, focal});
                    quo_next = {quo_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[FOCAL_W-1:0];
                    quo_next = {quo_next[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                low_reg[k+1] <= low_next;
                quo_reg[k+1] <= quo_next;
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // last stage: apply sign and clamp to the signed 32-bit range
    logic [QUO_W-1:0]   quo_f;
    logic [COORD_W-1:0] coord_next;
    logic [COORD_W-1:0] coord_reg;

    assign quo_f = quo_reg[DIV_STAGES];

    always_comb
    begin
        if (!neg_reg[DIV_STAGES])
        begin
            coord_next = (ovf_reg[DIV_STAGES] || quo_f[QUO_W-1]) ? 32'h7FFF_FFFF : quo_f;
        end
        else if (ovf_reg[DIV_STAGES] || (quo_f[QUO_W-1] && (quo_f[QUO_W-2:0] != '0)))
        begin
            coord_next = 32'h8000_0000;
        end
        else
        begin
            coord_next = ~quo_f + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

// File: rtl/dpb_outbuf.sv
// output register with a skid stage that freezes the pipeline only when both are full
module dpb_outbuf
    import dpb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [BUF_W-1:0] in_data,
    output logic             en,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [BUF_W-1:0] m_data
);

    logic             out_valid_reg;
    logic [BUF_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [BUF_W-1:0] skid_data_reg;

    assign en      = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_ready)
            begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_ready)
        begin
            out_valid_reg <= in_valid;
            out_data_reg  <= in_data;
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= in_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && in_valid))
        else $error("skid filled without a stalled output");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_ready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid item lost or changed while output stalled");

endmodule

// File: verif/point_checker.sv
`timescale 1ns / 100ps
// point checker for the depth back-projection block: mirrors the camera registers, predicts, compares
module point_checker
    import dpb_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // column, row, depth_mm, red_in, green_in, blue_in
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // point_x, point_y, point_z, red_out, green_out, blue_out
    input  logic [OUT_W-1:0]     m_axis_tdata,
    // point_valid
    input  logic                 m_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FOCAL_W-1:0]   cfg_wdata,
    output int                   points_in_flight,
    output int                   mismatch_count
);

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   row;
        logic [PIX_W-1:0]   column;
    } pixel_t;

    // output data with the valid flag from tuser appended at the bottom
    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [DEPTH_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic               valid;
    } point_t;

    logic [FOCAL_W-1:0]  focal_x_q;
    logic [FOCAL_W-1:0]  focal_y_q;
    logic [CENTER_W-1:0] center_x_q;
    logic [CENTER_W-1:0] center_y_q;

    point_t expected_points[$];
    point_t got_point;
    point_t want_point;

    // one coordinate in mm with 8 fractional bits, rounded half away from zero, clamped
    function automatic logic [COORD_W-1:0] project_coord(input logic [DEPTH_W-1:0] z,
                                                         input logic [PIX_W-1:0] pix,
                                                         input logic [CENTER_W-1:0] center,
                                                         input logic [FOCAL_W-1:0] focal);
        logic [63:0] pos;
        logic [63:0] ctr;
        logic [63:0] f;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] mag;
        logic        neg;
        pos = {52'd0, pix} << 8;
        ctr = {44'd0, center};
        f   = (focal == '0) ? 64'd1 : {40'd0, focal};
        neg = pos < ctr;
        d   = neg ? (ctr - pos) : (pos - ctr);
        num = {48'd0, z} * d * 64'd256;
        mag = (num + (f >> 1)) / f;
        if (!neg)
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        return 32'd0 - mag[31:0];
    endfunction

    function automatic point_t backproject(input pixel_t px);
        point_t pt;
        pt = '0;
        if (px.depth != '0 && px.column < MAX_COLUMNS && px.row < MAX_ROWS)
        begin
            pt.x     = project_coord(px.depth, px.column, center_x_q, focal_x_q);
            pt.y     = project_coord(px.depth, px.row, center_y_q, focal_y_q);
            pt.z     = px.depth;
            pt.red   = px.red;
            pt.green = px.green;
            pt.blue  = px.blue;
            pt.valid = 1'b1;
        end
        return pt;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_q  <= FOCAL_W'(256);
            focal_y_q  <= FOCAL_W'(256);
            center_x_q <= CENTER_W'(256);
            center_y_q <= CENTER_W'(256);
            expected_points.delete();
            points_in_flight <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FOCAL_X:  focal_x_q  <= cfg_wdata;
                    REG_FOCAL_Y:  focal_y_q  <= cfg_wdata;
                    REG_CENTER_X: center_x_q <= cfg_wdata[CENTER_W-1:0];
                    REG_CENTER_Y: center_y_q <= cfg_wdata[CENTER_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_points.push_back(backproject(pixel_t'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_point = point_t'({m_axis_tdata, m_axis_tuser});
                if (expected_points.size() == 0)
                begin
                    $error("point with no pixel pending: x %0d y %0d z %0d",
                           $signed(got_point.x), $signed(got_point.y), got_point.z);
                    mismatch_count++;
                end
                else
                begin
                    want_point = expected_points.pop_front();
                    check_field("point_x", $signed(want_point.x), $signed(got_point.x));
                    check_field("point_y", $signed(want_point.y), $signed(got_point.y));
                    check_field("point_z", want_point.z, got_point.z);
                    check_field("red_out", want_point.red, got_point.red);
                    check_field("green_out", want_point.green, got_point.green);
                    check_field("blue_out", want_point.blue, got_point.blue);
                    check_field("point_valid", want_point.valid, got_point.valid);
                end
            end
            points_in_flight <= expected_points.size();
        end
    end

endmodule

// File: verif/tb_depth_pixel_backprojection.sv
`timescale 1ns / 100ps
// testbench top for the depth back-projection block: clock, reset, pixel stimulus and verdict
module tb_depth_pixel_backprojection;
    import dpb_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    // column, row, depth_mm, red_in, green_in, blue_in
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // point_x, point_y, point_z, red_out, green_out, blue_out
    logic [OUT_W-1:0]     m_axis_tdata;
    // point_valid
    logic                 m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FOCAL_X;
    logic [FOCAL_W-1:0]   cfg_wdata = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int points_in_flight;
    int mismatch_count;

    // idling per phase: none, sender only, receiver only, both
    int send_idle_by_phase [4] = '{0, 71, 0, 17};
    int recv_stall_by_phase [4] = '{0, 0, 71, 17};

    depth_pixel_backprojection u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    point_checker u_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .points_in_flight (points_in_flight),
        .mismatch_count   (mismatch_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic send_pixel(input logic [PIX_W-1:0] column, input logic [PIX_W-1:0] row,
                              input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] red,
                              input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] blue);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tdata  <= {blue, green, red, depth, row, column};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        case ($urandom_range(0, 9))
            0:       depth = '0;
            1, 2:    depth = DEPTH_W'($urandom_range(1, 1023));
            default: depth = DEPTH_W'($urandom_range(1, 65535));
        endcase
        send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), depth,
                   COLOR_W'($urandom()), COLOR_W'($urandom()), COLOR_W'($urandom()));
    endtask

    // hold the sender until every point in flight has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (points_in_flight != 0);
    endtask

    task automatic load_camera(input logic [FOCAL_W-1:0] fx, input logic [FOCAL_W-1:0] fy,
                               input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_FOCAL_X;
        cfg_wdata <= fx;
        @(posedge clk);
        cfg_index <= REG_FOCAL_Y;
        cfg_wdata <= fy;
        @(posedge clk);
        cfg_index <= REG_CENTER_X;
        cfg_wdata <= FOCAL_W'(cx);
        @(posedge clk);
        cfg_index <= REG_CENTER_Y;
        cfg_wdata <= FOCAL_W'(cy);
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [FOCAL_W-1:0] random_focal();
        case ($urandom_range(0, 2))
            0:       return FOCAL_W'($urandom_range(1, 255));
            1:       return FOCAL_W'($urandom_range(256, 2048 * 256));
            default: return FOCAL_W'($urandom_range(1, 24'hFF_FFFF));
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // camera left at its reset values
        send_pixel(4095, 4095, 0, 255, 255, 255);
        send_pixel(0, 0, 1, 0, 0, 0);
        send_pixel(4095, 4095, 65535, 255, 255, 255);
        send_pixel(0, 0, 65535, 170, 85, 15);
        send_pixel(1, 1, 1234, 1, 2, 3);
        send_pixel(2048, 1024, 40000, 128, 64, 32);
        send_pixel(0, 4095, 0, 0, 0, 0);
        wait_drained();

        // zero focal length taken as one; x clamps negative, y clamps positive
        load_camera(0, 1, 20'hF_FFFF, 1);
        send_pixel(0, 4095, 65535, 255, 0, 255);
        send_pixel(4095, 0, 1, 0, 255, 0);
        send_pixel(100, 100, 1, 9, 8, 7);
        send_pixel(4095, 4095, 65535, 90, 91, 92);
        wait_drained();

        // even focal lengths so exact halves must round away from zero
        load_camera(512, 512, 1, 2049);
        send_pixel(0, 0, 1, 11, 22, 33);
        send_pixel(3, 9, 3, 44, 55, 66);
        send_pixel(4095, 4095, 65535, 77, 88, 99);
        send_pixel(8, 8, 0, 200, 201, 202);
        wait_drained();

        // widest focal length, principal point at the corner
        load_camera(24'hFF_FFFF, 24'hFF_FFFF, 1, 1);
        send_pixel(4095, 4095, 65535, 1, 1, 1);
        send_pixel(0, 0, 65535, 254, 254, 254);

        for (int cam = 0; cam < 5; cam++)
        begin
            wait_drained();
            case (cam)
                0:       load_camera(134400, 134400, 81792, 61312);
                1:       load_camera(1, 1, 20'hF_FFFF, 20'hF_FFFF);
                3:       load_camera(24'hFF_FFFF, 1, 1, 20'hF_FFFF);
                default: load_camera(random_focal(), random_focal(),
                                     CENTER_W'($urandom_range(1, 20'hF_FFFF)),
                                     CENTER_W'($urandom_range(1, 20'hF_FFFF)));
            endcase
            for (int phase = 0; phase < 4; phase++)
            begin
                send_idle_pct  = send_idle_by_phase[phase];
                recv_stall_pct = recv_stall_by_phase[phase];
                repeat (48) send_random_pixel();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
